### rtl/brf_pkg.sv
// shared widths, codes and result type for the byte ring fifo
`default_nettype none
package brf_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int MAX_BATCH_DEF = 64;

	localparam int OP_W   = 2;
	localparam int DATA_W = 8;
	localparam int LEN_W  = 8;
	localparam int CAP_W  = 11;
	localparam int MOV_W  = 7;
	localparam int OCC_W  = 11;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_PUT  = 2'd0,
		OP_GET  = 2'd1,
		OP_BPUT = 2'd2,
		OP_BGET = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_NO_DATA  = 2'd2
	} status_e;

	typedef struct packed {
		status_e             status;
		logic [DATA_W-1:0]   read_byte;
		logic [MOV_W-1:0]    moved;
		logic [OCC_W-1:0]    occ;
		logic                last;
	} res_t;

endpackage
`default_nettype wire

### rtl/brf_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/brf_ctrl.sv
// fifo control: indices, fill count, batch state and the byte store
`default_nettype none
module brf_ctrl #(
	parameter int DEPTH     = brf_pkg::DEPTH_DEF,
	parameter int MAX_BATCH = brf_pkg::MAX_BATCH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cap_we,
	input  wire logic [brf_pkg::CAP_W-1:0]     cap_wdata,
	input  wire logic                          acc,
	input  wire logic [brf_pkg::OP_W-1:0]      op,
	input  wire logic [brf_pkg::DATA_W-1:0]    data,
	input  wire logic [brf_pkg::LEN_W-1:0]     batch_len,
	input  wire logic                          batch_first,
	input  wire logic                          out_free,
	output logic                               busy,
	output logic                               res_load,
	output brf_pkg::res_t                      res
);

	localparam int IW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > brf_pkg::CAP_W) ? FW : brf_pkg::CAP_W;
	localparam int BW = $clog2(MAX_BATCH + 1);
	localparam int MW = brf_pkg::MOV_W;
	localparam int OW = brf_pkg::OCC_W;

	logic [brf_pkg::CAP_W-1:0] cap_q;
	logic [IW-1:0]             wr_idx_q, rd_idx_q, wr_idx_d, rd_idx_d;
	logic [FW-1:0]             fill_q, fill_d;
	logic                      adm_q, adm_d;
	logic [BW-1:0]             left_q, left_d;
	logic [BW-1:0]             rem_q, rem_d;
	logic [BW-1:0]             iss_q, iss_d;
	logic                      pend_q, pend_d;
	logic [MW-1:0]             moved_s1;
	logic [OW-1:0]             occ_s1;
	logic                      last_s1;

	logic [CW-1:0] cap_c, eff_cap, fill_c, free_space;
	logic          full;
	logic          do_push, issue;
	logic          ram_we, ram_re;
	logic [brf_pkg::DATA_W-1:0] ram_rdata;

	function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx, input logic [CW-1:0] lim);
		logic [CW-1:0] n;
		n = CW'(idx) + CW'(1);
		return (n >= lim) ? '0 : IW'(n);
	endfunction

	assign cap_c   = CW'(cap_q);
	assign eff_cap = (cap_c == '0) ? CW'(1) : ((cap_c > CW'(DEPTH)) ? CW'(DEPTH) : cap_c);
	assign fill_c  = CW'(fill_q);
	assign full    = fill_c >= eff_cap;
	assign free_space = full ? '0 : eff_cap - fill_c;

	assign busy  = (rem_q != '0) || pend_q;
	assign issue = !acc && (rem_q != '0) && (!pend_q || out_free);

	always_comb begin
		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		fill_d   = fill_q;
		adm_d    = adm_q;
		left_d   = left_q;
		rem_d    = rem_q;
		iss_d    = iss_q;
		pend_d   = pend_q;
		do_push  = 1'b0;
		ram_re   = 1'b0;
		res_load = 1'b0;
		res      = '{brf_pkg::ST_DONE, '0, '0, OW'(fill_q), 1'b1};

		if (acc) begin
			res_load = 1'b1;
			case (brf_pkg::op_e'(op))
				brf_pkg::OP_PUT: begin
					if (full) begin
						res.status = brf_pkg::ST_NO_SPACE;
					end else begin
						do_push = 1'b1;
					end
				end
				brf_pkg::OP_GET: begin
					if (fill_q == '0) begin
						res.status = brf_pkg::ST_NO_DATA;
					end else begin
						res_load = 1'b0;
						rem_d    = BW'(1);
						iss_d    = '0;
					end
				end
				brf_pkg::OP_BPUT: begin
					if (batch_first) begin
						adm_d  = 1'b0;
						left_d = '0;
						if (batch_len == '0) begin
							res.status = brf_pkg::ST_DONE;
						end else if (batch_len > brf_pkg::LEN_W'(MAX_BATCH) ||
							CW'(batch_len) > free_space) begin
							res.status = brf_pkg::ST_NO_SPACE;
						end else begin
							do_push = 1'b1;
							left_d  = BW'(batch_len) - BW'(1);
							adm_d   = BW'(batch_len) != BW'(1);
						end
					end else if (!adm_q || left_q == '0 || full) begin
						adm_d      = 1'b0;
						left_d     = '0;
						res.status = brf_pkg::ST_NO_SPACE;
					end else begin
						do_push = 1'b1;
						left_d  = left_q - BW'(1);
						adm_d   = left_q != BW'(1);
					end
				end
				brf_pkg::OP_BGET: begin
					if (batch_len > brf_pkg::LEN_W'(MAX_BATCH) || CW'(batch_len) > fill_c) begin
						res.status = brf_pkg::ST_NO_DATA;
					end else if (batch_len != '0) begin
						res_load = 1'b0;
						rem_d    = BW'(batch_len);
						iss_d    = '0;
					end
				end
				default: begin
					res.status = brf_pkg::ST_NO_DATA;
				end
			endcase
			if (do_push) begin
				wr_idx_d  = adv(wr_idx_q, eff_cap);
				fill_d    = fill_q + FW'(1);
				res.moved = MW'(1);
				res.occ   = OW'(fill_q + FW'(1));
			end
		end else begin
			// move the byte sitting on the ram output into the output register
			if (pend_q && out_free) begin
				res_load = 1'b1;
				res      = '{brf_pkg::ST_DONE, ram_rdata, moved_s1, occ_s1, last_s1};
				pend_d   = 1'b0;
			end
			if (issue) begin
				ram_re   = 1'b1;
				rd_idx_d = adv(rd_idx_q, eff_cap);
				fill_d   = fill_q - FW'(1);
				rem_d    = rem_q - BW'(1);
				iss_d    = iss_q + BW'(1);
				pend_d   = 1'b1;
			end
		end
	end

	assign ram_we = do_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= brf_pkg::CAP_RESET;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
			adm_q    <= 1'b0;
			left_q   <= '0;
			rem_q    <= '0;
			iss_q    <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			fill_q   <= fill_d;
			adm_q    <= adm_d;
			left_q   <= left_d;
			rem_q    <= rem_d;
			iss_q    <= iss_d;
			pend_q   <= pend_d;
		end
	end

	// per-read result fields travel alongside the ram read
	always_ff @(posedge clk) begin
		if (issue) begin
			moved_s1 <= MW'(iss_q) + MW'(1);
			occ_s1   <= OW'(fill_q - FW'(1));
			last_s1  <= rem_q == BW'(1);
		end
	end

	brf_ram #(
		.WIDTH(brf_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_q),
		.wdata(data),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill count beyond store depth");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (rem_q == '0 && !pend_q))
		else $error("store write while a get is in flight");
	a_read_data: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> fill_q != '0)
		else $error("store read with nothing stored");
	a_batch_state: assert property (@(posedge clk) disable iff (!arst_n)
		adm_q == (left_q != '0))
		else $error("batch admit flag and remaining count disagree");
	a_pend_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && out_free && rem_q == '0) |=> !pend_q)
		else $error("read byte not moved to output");
`endif

endmodule
`default_nettype wire

### rtl/byte_ring_fifo_batch_unit.sv
// top level of the byte ring fifo with batch put and get
// Byte FIFO over a circular store whose used size is set by the capacity register (the user
// must see that it is written only while idle; the block does not enforce it). Puts, batch put
// elements, refusals and zero-length batch gets give one result loaded in the transfer cycle,
// so such items can follow every cycle while the output does not stall. A get of n bytes (n = 1 for
// a single get) holds the input until it is done, reading one byte per cycle through the single read
// port with registered read data and giving results on consecutive cycles while the output side does
// not stall. The store needs no clearing after reset; bytes are always written before they are read.
`default_nettype none
module byte_ring_fifo_batch_unit #(
	parameter int DEPTH     = brf_pkg::DEPTH_DEF,
	parameter int MAX_BATCH = brf_pkg::MAX_BATCH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          capacity_we,
	input  wire logic [brf_pkg::CAP_W-1:0]     capacity,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [brf_pkg::OP_W-1:0]      op,
	input  wire logic [brf_pkg::DATA_W-1:0]    data,
	input  wire logic [brf_pkg::LEN_W-1:0]     batch_len,
	input  wire logic                          batch_first,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic [brf_pkg::DATA_W-1:0]         read_byte,
	output logic [brf_pkg::MOV_W-1:0]          moved_count,
	output logic [brf_pkg::OCC_W-1:0]          occupancy,
	output logic                               last
);

	logic          out_valid_q;
	brf_pkg::res_t out_q;
	brf_pkg::res_t res;
	logic          res_load, busy, out_free, acc;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy || !out_free;
	assign acc      = in_valid && !in_stall;

	brf_ctrl #(
		.DEPTH    (DEPTH),
		.MAX_BATCH(MAX_BATCH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap_we     (capacity_we),
		.cap_wdata  (capacity),
		.acc        (acc),
		.op         (op),
		.data       (data),
		.batch_len  (batch_len),
		.batch_first(batch_first),
		.out_free   (out_free),
		.busy       (busy),
		.res_load   (res_load),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign read_byte   = out_q.read_byte;
	assign moved_count = out_q.moved;
	assign occupancy   = out_q.occ;
	assign last        = out_q.last;

endmodule
`default_nettype wire
